// ===== rtl/core/sclg_pkg.sv =====
// ----------------------------------------------------------------------------
// sclg_pkg: shared types and constants of the shuffled combined LCG
// Moduli, multipliers, fold constants and the step unit's result record.
// ----------------------------------------------------------------------------
package sclg_pkg;

	localparam int VAL_W = 31;
	localparam int MUL_W = 16;
	localparam int PROD_W = VAL_W + MUL_W;

	localparam logic [VAL_W-1:0] MOD_ONE = 31'd2147483563;
	localparam logic [VAL_W-1:0] MOD_TWO = 31'd2147483399;
	localparam logic [MUL_W-1:0] MUL_ONE = 16'd40014;
	localparam logic [MUL_W-1:0] MUL_TWO = 16'd40692;

	// 2^31 minus each modulus, used to fold the high product bits back in
	localparam logic [7:0] FOLD_ONE = 8'(64'd2147483648 - 64'(MOD_ONE));
	localparam logic [7:0] FOLD_TWO = 8'(64'd2147483648 - 64'(MOD_TWO));

	localparam logic [VAL_W-1:0] WRAP_TOP = MOD_ONE - 31'd1;
	localparam logic [VAL_W-1:0] GEN1_RESET = 31'd1;
	localparam logic [VAL_W-1:0] GEN2_RESET = 31'd123456789;

	localparam int WARM_EXTRA = 8;

	localparam int IDX_PRE_SHIFT = 15;
	localparam int IDX_RECIP_SHIFT = 40;

	typedef struct packed {
		logic done;
		logic [VAL_W-1:0] g1;
		logic [VAL_W-1:0] g2;
	} step_res_t;

endpackage

// ===== rtl/core/sclg_step.sv =====
// ----------------------------------------------------------------------------
// sclg_step: two-lane modular multiply step
// Stage one forms both constant products, stage two folds each product into
// its modulus with one compare and subtract. Results hold until the next start.
// ----------------------------------------------------------------------------
module sclg_step (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sclg_pkg::VAL_W-1:0] a1,
	input  logic [sclg_pkg::VAL_W-1:0] a2,
	output sclg_pkg::step_res_t        res
);
	import sclg_pkg::*;

	logic              vld_s1;
	logic              vld_s2;
	logic [PROD_W-1:0] p1_s1;
	logic [PROD_W-1:0] p2_s1;
	logic [VAL_W-1:0]  g1_s2;
	logic [VAL_W-1:0]  g2_s2;

	function automatic logic [VAL_W-1:0] fold_mod(
		input logic [PROD_W-1:0] p,
		input logic [7:0]        c,
		input logic [VAL_W-1:0]  m
	);
		logic [VAL_W:0] f;
		f = (VAL_W+1)'(p[VAL_W-1:0]) + (VAL_W+1)'(p[PROD_W-1:VAL_W]) * (VAL_W+1)'(c);
		if (f >= (VAL_W+1)'(m)) begin
			f = f - (VAL_W+1)'(m);
		end
		return f[VAL_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p1_s1 <= PROD_W'(a1) * PROD_W'(MUL_ONE);
			p2_s1 <= PROD_W'(a2) * PROD_W'(MUL_TWO);
		end
		if (vld_s1) begin
			g1_s2 <= fold_mod(p1_s1, FOLD_ONE, MOD_ONE);
			g2_s2 <= fold_mod(p2_s1, FOLD_TWO, MOD_TWO);
		end
	end

	assign res.done = vld_s2;
	assign res.g1 = g1_s2;
	assign res.g2 = g2_s2;

endmodule

// ===== rtl/core/sclg_index.sv =====
// ----------------------------------------------------------------------------
// sclg_index: table index from the previous output
// Divides by the slice width with a short reciprocal estimate, one product
// back-check and a single correction, over three register stages.
// ----------------------------------------------------------------------------
module sclg_index #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [sclg_pkg::VAL_W-1:0]      din,
	output logic                            ready,
	output logic [$clog2(TABLE_DEPTH)-1:0]  idx
);
	import sclg_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int QW = $clog2(TABLE_DEPTH + 2);
	localparam longint unsigned SLICE = 64'd1 + 64'(WRAP_TOP) / 64'(TABLE_DEPTH);
	localparam longint unsigned RECIP = (64'd1 << IDX_RECIP_SHIFT) / SLICE;
	localparam int RECIP_W = $clog2(RECIP + 64'd1);
	localparam int TOP_W = VAL_W - IDX_PRE_SHIFT;
	localparam int PROD_IW = TOP_W + RECIP_W;
	localparam int BND_W = QW + VAL_W;
	localparam int QSH = IDX_RECIP_SHIFT - IDX_PRE_SHIFT;
	localparam logic [QW-1:0] LAST = QW'(TABLE_DEPTH - 1);

	logic               vld_s1;
	logic               vld_s2;
	logic [PROD_IW-1:0] prod_s1;
	logic [VAL_W-1:0]   v_s1;
	logic [VAL_W-1:0]   v_s2;
	logic [QW-1:0]      q_s2;
	logic [BND_W-1:0]   bnd_s2;
	logic [QW-1:0]      qe;
	logic [QW-1:0]      qn;
	logic [QW-1:0]      qsat;
	logic               ready_q;
	logic [IDX_W-1:0]   idx_q;

	assign qe = QW'(prod_s1 >> QSH);

	always_comb begin
		qn = (BND_W'(v_s2) >= bnd_s2) ? QW'(q_s2 + QW'(1)) : q_s2;
		qsat = (qn > LAST) ? LAST : qn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			ready_q <= 1'b1;
			idx_q <= '0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			if (start) begin
				ready_q <= 1'b0;
			end else if (vld_s2) begin
				ready_q <= 1'b1;
			end
			if (vld_s2) begin
				idx_q <= IDX_W'(qsat);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= PROD_IW'(din[VAL_W-1:IDX_PRE_SHIFT]) * PROD_IW'(RECIP);
			v_s1 <= din;
		end
		if (vld_s1) begin
			q_s2 <= qe;
			bnd_s2 <= BND_W'(QW'(qe + QW'(1))) * BND_W'(SLICE);
			v_s2 <= v_s1;
		end
	end

	assign ready = ready_q;
	assign idx = idx_q;

endmodule

// ===== rtl/core/sclg_table.sv =====
// ----------------------------------------------------------------------------
// sclg_table: shuffle table memory
// One write and one registered read per cycle; entries never written read
// as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module sclg_table #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            re,
	input  logic [$clog2(TABLE_DEPTH)-1:0]  raddr,
	input  logic                            we,
	input  logic [$clog2(TABLE_DEPTH)-1:0]  waddr,
	input  logic [sclg_pkg::VAL_W-1:0]      wdata,
	output logic [sclg_pkg::VAL_W-1:0]      rdata
);
	import sclg_pkg::*;

	logic [VAL_W-1:0]       mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [VAL_W-1:0]       rdata_q;
	logic                   rvld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
			rvld_q <= valid_q[raddr];
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

// ===== rtl/core/shuffled_combined_lcg_generator_top.sv =====
// ----------------------------------------------------------------------------
// shuffled_combined_lcg_generator_top: shuffled combined LCG generator
// Two multiplicative congruential generators behind a shuffle table; a seed
// command refills the table, and every command returns one number.
// ----------------------------------------------------------------------------
// Every accepted item returns one value in 1..2147483562. A draw passes
// through the two-lane modular multiplier (overlapping the registered table
// read), then through the index divider that turns the new output into the
// next table address; a new item is taken only once that address is ready.
// A seed command first runs TABLE_DEPTH+8 warm-up steps through the
// multiplier, then draws as any other item does. An output register holds a
// finished value while the next item is taken in.
// ----------------------------------------------------------------------------
module shuffled_combined_lcg_generator_top #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  logic                       cmd,
	input  logic [sclg_pkg::VAL_W-1:0] seed_value,
	output logic                       value_valid,
	input  logic                       value_stall,
	output logic [sclg_pkg::VAL_W-1:0] value
);
	import sclg_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + WARM_EXTRA);
	localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(TABLE_DEPTH + WARM_EXTRA - 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_WARM = 5'b00010,
		ST_PEND = 5'b00100,
		ST_READ = 5'b01000,
		ST_HOLD = 5'b10000
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [VAL_W-1:0] gen1_q;
	logic [VAL_W-1:0] gen2_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VAL_W-1:0] value_q;
	logic             value_valid_q;

	logic             acc;
	logic [VAL_W-1:0] seed_s;
	logic             slot_free;
	logic             warm_done;
	logic             warm_last;
	logic             launch;
	logic             do_combine;
	logic             step_start;
	logic [VAL_W-1:0] step_a1;
	step_res_t        step_res;
	logic             idx_start;
	logic [VAL_W-1:0] idx_din;
	logic             idx_ready;
	logic [IDX_W-1:0] idx;
	logic             tbl_we;
	logic [IDX_W-1:0] tbl_waddr;
	logic [VAL_W-1:0] tbl_rdata;
	logic [VAL_W:0]   diff;
	logic [VAL_W-1:0] y;

	assign cmd_stall = !((state_q == ST_IDLE) && idx_ready);
	assign acc = cmd_valid && !cmd_stall;
	assign seed_s = (seed_value == '0) ? VAL_W'(1) : seed_value;
	assign slot_free = !value_valid_q || !value_stall;
	assign warm_done = (state_q == ST_WARM) && step_res.done;
	assign warm_last = warm_done && (cnt_q == '0);
	assign launch = (acc && !cmd) || ((state_q == ST_PEND) && idx_ready);
	assign do_combine = (((state_q == ST_READ) && step_res.done) || (state_q == ST_HOLD))
		&& slot_free;
	assign step_start = acc || launch || (warm_done && !warm_last);

	always_comb begin
		priority if (state_q == ST_WARM) begin
			step_a1 = step_res.g1;
		end else if ((state_q == ST_IDLE) && cmd) begin
			step_a1 = seed_s;
		end else begin
			step_a1 = gen1_q;
		end
	end

	// wrap the shuffled difference back into 1..WRAP_TOP
	always_comb begin
		diff = {1'b0, tbl_rdata} - {1'b0, step_res.g2};
		if (diff[VAL_W] || (diff == '0)) begin
			y = VAL_W'(diff + (VAL_W+1)'(WRAP_TOP));
		end else begin
			y = diff[VAL_W-1:0];
		end
	end

	assign tbl_we = do_combine || (warm_done && (cnt_q < CNT_W'(TABLE_DEPTH)));
	assign tbl_waddr = (state_q == ST_WARM) ? cnt_q[IDX_W-1:0] : idx;
	assign idx_start = do_combine || warm_last;
	assign idx_din = (state_q == ST_WARM) ? step_res.g1 : y;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_d = cmd ? ST_WARM : ST_READ;
				end
			end
			ST_WARM: begin
				if (warm_last) begin
					state_d = ST_PEND;
				end
			end
			ST_PEND: begin
				if (idx_ready) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (step_res.done) begin
					state_d = slot_free ? ST_IDLE : ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gen1_q <= GEN1_RESET;
			gen2_q <= GEN2_RESET;
			cnt_q <= '0;
			value_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc && cmd) begin
				gen1_q <= seed_s;
				gen2_q <= seed_s;
				cnt_q <= CNT_INIT;
			end
			if (warm_done) begin
				gen1_q <= step_res.g1;
				if (!warm_last) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			if (do_combine) begin
				gen1_q <= step_res.g1;
				gen2_q <= step_res.g2;
			end
			if (do_combine) begin
				value_valid_q <= 1'b1;
			end else if (!value_stall) begin
				value_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_combine) begin
			value_q <= y;
		end
	end

	assign value_valid = value_valid_q;
	assign value = value_q;

	sclg_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (step_start),
		.a1     (step_a1),
		.a2     (gen2_q),
		.res    (step_res)
	);

	sclg_index #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_index (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (idx_start),
		.din    (idx_din),
		.ready  (idx_ready),
		.idx    (idx)
	);

	sclg_table #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (launch),
		.raddr  (idx),
		.we     (tbl_we),
		.waddr  (tbl_waddr),
		.wdata  (step_res.g1),
		.rdata  (tbl_rdata)
	);

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(launch && tbl_we))
		else $error("table read and write in the same cycle");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid_q |-> ((value_q != '0) && (value_q <= WRAP_TOP)))
		else $error("value out of range");

	a_step_owner: assert property (@(posedge clk) disable iff (!arst_n)
		step_res.done |-> ((state_q == ST_READ) || (state_q == ST_WARM)))
		else $error("step result with no consumer");

	a_index_busy: assert property (@(posedge clk) disable iff (!arst_n)
		do_combine |=> !idx_ready)
		else $error("index not recomputed after a draw");

endmodule
